[rtl/core/tshl_pkg.sv]
package tshl_pkg;

    // ring geometry
    localparam int HISTORY_DEPTH = 8;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    // field widths
    localparam int TIME_W   = 64;
    localparam int ACC_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 1;

    // stream word widths, padded to whole bytes
    localparam int IN_BITS      = TIME_W + 1 + 3 * ACC_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = 1 + 3 + 1 + 3 * ACC_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // register reset values
    localparam logic [CFG_W-1:0] MAX_FRESH_RST = CFG_W'(20000);
    localparam logic [CFG_W-1:0] HOLD_LIMIT_RST = CFG_W'(100000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_FRESH  = 1'b0,
        REG_HOLD_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CAPTURE = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        OUT_FRESH      = 3'd0,
        OUT_INVALID    = 3'd1,
        OUT_STALE      = 3'd2,
        OUT_NONE       = 3'd3,
        OUT_NOT_LOOKUP = 3'd4
    } outcome_t;

    // one ring entry; time in the lowest bits, same layout as the input word
    typedef struct packed {
        logic signed [ACC_W-1:0] az;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] ax;
        logic                    ok;
        logic [TIME_W-1:0]       ts;
    } entry_t;

    // age check of one entry against the query time
    typedef struct packed {
        logic causal;
        logic fresh;
        logic holdable;
    } verdict_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] fill;
    } status_t;

endpackage

[rtl/core/tshl_ram.sv]
module tshl_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/tshl_age_chk.sv]
module tshl_age_chk (
    input  logic [tshl_pkg::TIME_W-1:0] entry_ts,
    input  logic [tshl_pkg::TIME_W-1:0] query_ts,
    input  logic [tshl_pkg::CFG_W-1:0]  fresh_lim,
    input  logic [tshl_pkg::CFG_W-1:0]  hold_lim,
    output tshl_pkg::verdict_t          verdict
);

    logic [tshl_pkg::TIME_W-1:0] age;
    logic                        age_hi_zero;

    // age only matters for causal entries, so the wrap of the subtract is harmless
    assign age         = query_ts - entry_ts;
    assign age_hi_zero = (age[tshl_pkg::TIME_W-1:tshl_pkg::CFG_W] == '0);

    assign verdict.causal   = (entry_ts <= query_ts);
    assign verdict.fresh    = age_hi_zero && (age[tshl_pkg::CFG_W-1:0] <= fresh_lim);
    assign verdict.holdable = age_hi_zero && (age[tshl_pkg::CFG_W-1:0] <= hold_lim);

endmodule

[rtl/core/tshl_engine.sv]
module tshl_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tshl_pkg::CMD_W-1:0]        s_tuser,
    input  logic [tshl_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tshl_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic [tshl_pkg::CFG_W-1:0]        fresh_lim,
    input  logic [tshl_pkg::CFG_W-1:0]        hold_lim,
    output tshl_pkg::status_t                 status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    localparam logic [tshl_pkg::PTR_W-1:0] LAST_SLOT =
        tshl_pkg::PTR_W'(tshl_pkg::HISTORY_DEPTH - 1);
    localparam logic [tshl_pkg::CNT_W-1:0] FULL_CNT =
        tshl_pkg::CNT_W'(tshl_pkg::HISTORY_DEPTH);

    state_t                              state_reg, state_next;
    logic [tshl_pkg::PTR_W-1:0]          wp_reg, wp_next;
    logic [tshl_pkg::CNT_W-1:0]          fill_reg, fill_next;
    logic [tshl_pkg::TIME_W-1:0]         last_ts_reg, last_ts_next;
    logic                                last_ok_reg, last_ok_next;
    logic                                have_last_reg, have_last_next;
    logic [tshl_pkg::TIME_W-1:0]         query_reg, query_next;
    logic [tshl_pkg::PTR_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [tshl_pkg::CNT_W-1:0]          rem_reg, rem_next;
    logic                                found_reg, found_next;
    logic                                res_stored_reg, res_stored_next;
    tshl_pkg::outcome_t                  res_outcome_reg, res_outcome_next;
    logic                                res_present_reg, res_present_next;
    logic signed [tshl_pkg::ACC_W-1:0]   res_ax_reg, res_ax_next;
    logic signed [tshl_pkg::ACC_W-1:0]   res_ay_reg, res_ay_next;
    logic signed [tshl_pkg::ACC_W-1:0]   res_az_reg, res_az_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [tshl_pkg::OUT_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    tshl_pkg::entry_t                    in_entry;
    tshl_pkg::entry_t                    wr_entry;
    tshl_pkg::entry_t                    rd_entry;
    tshl_pkg::verdict_t                  verdict;
    logic                                cap_store;
    logic [tshl_pkg::PTR_W-1:0]          start_idx;
    logic [tshl_pkg::PTR_W-1:0]          prev_idx;
    logic [tshl_pkg::PTR_W-1:0]          wp_inc;
    logic                                walk_first;
    logic                                walk_take;
    logic                                ram_we;
    logic                                ram_re;
    logic [tshl_pkg::PTR_W-1:0]          ram_raddr;

    assign in_entry = tshl_pkg::entry_t'(s_tdata[tshl_pkg::IN_BITS-1:0]);

    // invalid samples are kept with zeroed acceleration
    always_comb
    begin
        wr_entry    = in_entry;
        if (!in_entry.ok)
        begin
            wr_entry.ax = '0;
            wr_entry.ay = '0;
            wr_entry.az = '0;
        end
    end

    assign cap_store = (in_entry.ts != '0) &&
                       !(have_last_reg && (in_entry.ts == last_ts_reg) &&
                         (in_entry.ok == last_ok_reg));

    assign wp_inc    = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
    assign start_idx = (wp_reg == '0) ? LAST_SLOT : wp_reg - 1'b1;
    assign prev_idx  = (rd_idx_reg == '0) ? LAST_SLOT : rd_idx_reg - 1'b1;

    tshl_ram #(
        .DEPTH (tshl_pkg::HISTORY_DEPTH),
        .WIDTH ($bits(tshl_pkg::entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    tshl_age_chk u_age_chk (
        .entry_ts  (rd_entry.ts),
        .query_ts  (query_reg),
        .fresh_lim (fresh_lim),
        .hold_lim  (hold_lim),
        .verdict   (verdict)
    );

    assign walk_first = verdict.causal && !found_reg;
    assign walk_take  = verdict.causal && rd_entry.ok &&
                        ((walk_first && verdict.fresh) || verdict.holdable);

    always_comb
    begin
        state_next       = state_reg;
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        last_ts_next     = last_ts_reg;
        last_ok_next     = last_ok_reg;
        have_last_next   = have_last_reg;
        query_next       = query_reg;
        rd_idx_next      = rd_idx_reg;
        rem_next         = rem_reg;
        found_next       = found_reg;
        res_stored_next  = res_stored_reg;
        res_outcome_next = res_outcome_reg;
        res_present_next = res_present_reg;
        res_ax_next      = res_ax_reg;
        res_ay_next      = res_ay_reg;
        res_az_next      = res_az_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = prev_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_stored_next  = 1'b0;
                    res_outcome_next = tshl_pkg::OUT_NOT_LOOKUP;
                    res_present_next = 1'b0;
                    res_ax_next      = '0;
                    res_ay_next      = '0;
                    res_az_next      = '0;
                    state_next       = ST_DONE;
                    unique case (s_tuser)
                        tshl_pkg::CMD_CAPTURE:
                        begin
                            if (cap_store)
                            begin
                                ram_we          = 1'b1;
                                wp_next         = wp_inc;
                                fill_next       = (fill_reg == FULL_CNT) ? fill_reg
                                                                         : fill_reg + 1'b1;
                                last_ts_next    = in_entry.ts;
                                last_ok_next    = in_entry.ok;
                                have_last_next  = 1'b1;
                                res_stored_next = 1'b1;
                            end
                        end
                        tshl_pkg::CMD_LOOKUP:
                        begin
                            res_outcome_next = tshl_pkg::OUT_NONE;
                            query_next       = in_entry.ts;
                            found_next       = 1'b0;
                            rem_next         = fill_reg;
                            rd_idx_next      = start_idx;
                            ram_re           = 1'b1;
                            ram_raddr        = start_idx;
                            if (fill_reg != '0)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        tshl_pkg::CMD_CLEAR:
                        begin
                            wp_next        = '0;
                            fill_next      = '0;
                            last_ts_next   = '0;
                            last_ok_next   = 1'b0;
                            have_last_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // data of rd_idx_reg arrives; next older entry is fetched meanwhile
                ram_re      = 1'b1;
                rd_idx_next = prev_idx;
                rem_next    = rem_reg - 1'b1;
                if (verdict.causal)
                begin
                    found_next = 1'b1;
                end
                if (walk_first)
                begin
                    if (!rd_entry.ok)
                    begin
                        res_outcome_next = tshl_pkg::OUT_INVALID;
                    end
                    else if (!verdict.fresh)
                    begin
                        res_outcome_next = tshl_pkg::OUT_STALE;
                    end
                    else
                    begin
                        res_outcome_next = tshl_pkg::OUT_FRESH;
                    end
                end
                if (walk_take)
                begin
                    res_present_next = 1'b1;
                    res_ax_next      = rd_entry.ax;
                    res_ay_next      = rd_entry.ay;
                    res_az_next      = rd_entry.az;
                end
                // nothing later can change the result once data is chosen
                if (walk_take || (rem_reg == tshl_pkg::CNT_W'(1)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = tshl_pkg::OUT_TDATA_W'({res_az_reg, res_ay_reg,
                                                            res_ax_reg, res_present_reg,
                                                            res_outcome_reg,
                                                            res_stored_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            last_ts_reg   <= '0;
            last_ok_reg   <= 1'b0;
            have_last_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            last_ts_reg   <= last_ts_next;
            last_ok_reg   <= last_ok_next;
            have_last_reg <= have_last_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg       <= query_next;
        rd_idx_reg      <= rd_idx_next;
        rem_reg         <= rem_next;
        found_reg       <= found_next;
        res_stored_reg  <= res_stored_next;
        res_outcome_reg <= res_outcome_next;
        res_present_reg <= res_present_next;
        res_ax_reg      <= res_ax_next;
        res_ay_reg      <= res_ay_next;
        res_az_reg      <= res_az_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.fill = fill_reg;

endmodule

[rtl/core/timestamped_sample_history_lookup_unit.sv]
// History of the latest timestamped three-axis acceleration samples with a causal
// lookup. A capture word (tuser 0) writes its sample into the next ring slot,
// acceleration zeroed when sample_ok is low; it is dropped (stored 0) when its
// timestamp is zero or when timestamp and validity both repeat the last capture.
// A lookup word (tuser 1) walks the ring newest-first from a single-port-read
// synchronous RAM, one entry a cycle, skipping entries newer than the query time;
// the first entry at or before the query time sets the outcome (fresh, invalid,
// stale), and otherwise the newest valid entry no older than hold_limit_us is
// returned as held data. A clear word (tuser 2) empties the ring; tuser 3 changes
// nothing. Every word gives exactly one result word. Capture, clear and the unused
// code go from acceptance to the DONE state and on to the result; a lookup first
// walks up to HISTORY_DEPTH ring entries (8 by default) in the WALK state, the walk
// reading one RAM entry per cycle. A new word is taken once the previous one has
// its result queued in the output register, even while that result is still
// waiting for m_tready. Registers are to be written only while the unit is idle;
// the unit does not enforce this, and there is no read-back.
module timestamped_sample_history_lookup_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tshl_pkg::CMD_W-1:0]           s_tuser,  // cmd
    // time_us, sample_ok, accel_x_in, accel_y_in, accel_z_in, zero pad
    input  logic [tshl_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // stored, outcome, data_present, accel_x_out, accel_y_out, accel_z_out, zero pad
    output logic [tshl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // register writes: 0 max_fresh_age_us, 1 hold_limit_us
    input  logic                                 cfg_we,
    input  logic [tshl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tshl_pkg::CFG_W-1:0]           cfg_data
);

    logic [tshl_pkg::CFG_W-1:0] max_fresh_reg;
    logic [tshl_pkg::CFG_W-1:0] hold_limit_reg;
    tshl_pkg::status_t          status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fresh_reg  <= tshl_pkg::MAX_FRESH_RST;
            hold_limit_reg <= tshl_pkg::HOLD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tshl_pkg::REG_MAX_FRESH:  max_fresh_reg  <= cfg_data;
                tshl_pkg::REG_HOLD_LIMIT: hold_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer, ring RAM and age check
    tshl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fresh_lim (max_fresh_reg),
        .hold_lim  (hold_limit_reg),
        .status    (status)
    );

    // fill count saturates at the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.fill <= tshl_pkg::CNT_W'(tshl_pkg::HISTORY_DEPTH))
        else $error("fill count beyond ring depth");

    // one word in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> status.busy)
        else $error("unit idle right after accepting a word");

    // no data carried means zero acceleration fields
    a_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[4]) |-> (m_tdata[100:5] == '0))
        else $error("acceleration present without data_present");

    // a stored capture never reports lookup content
    a_stored_not_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |->
            ((m_tdata[3:1] == tshl_pkg::OUT_NOT_LOOKUP) && !m_tdata[4]))
        else $error("stored flag on a lookup result");

    // data is returned only for a lookup that found a causal entry
    a_present_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |->
            ((m_tdata[3:1] == tshl_pkg::OUT_FRESH) ||
             (m_tdata[3:1] == tshl_pkg::OUT_INVALID) ||
             (m_tdata[3:1] == tshl_pkg::OUT_STALE)))
        else $error("data present with a non-causal outcome");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import tshl_pkg::*;

    // cmd code with no operation behind it; answers like a clear
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [TIME_W-1:0] TS_MAX = '1;

    // result word layout: stored, outcome[2:0], data_present, then x, y, z
    localparam int RES_ACC_LSB = 5;

    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 92;
    // phase in which the sink holds off for a long stretch
    localparam int HOLD_PHASE      = 3;
    localparam int HOLD_OFF_CYCLES = 200;
    // the hold-off plus the worst gap, stall and walk, taken several times over
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 200;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [TIME_W-1:0]       ts;
        logic                    ok;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
    } word_t;

    typedef struct packed {
        logic                    stored;
        logic [2:0]              outcome;
        logic                    present;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
    } result_t;

    // one line of the directed table; typed rows carry their answer
    typedef struct packed {
        word_t   w;
        logic    typed;
        result_t want;
    } row_t;

    // ---------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [CMD_W-1:0]       s_tuser   = '0;   // cmd
    // time_us, sample_ok, accel_x_in, accel_y_in, accel_z_in, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // stored, outcome, data_present, accel_x_out, accel_y_out, accel_z_out, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // travel alongside the offered word so the monitor knows a typed answer
    logic    row_typed = 1'b0;
    result_t row_want  = '0;

    timestamped_sample_history_lookup_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Sample ring as the predictor sees it
    // ---------------------------------------------------------------
    logic [TIME_W-1:0] ring_ts [HISTORY_DEPTH];
    logic              ring_ok [HISTORY_DEPTH];
    logic [ACC_W-1:0]  ring_ax [HISTORY_DEPTH];
    logic [ACC_W-1:0]  ring_ay [HISTORY_DEPTH];
    logic [ACC_W-1:0]  ring_az [HISTORY_DEPTH];
    int unsigned       wr_slot;
    int unsigned       used_slots;
    logic [TIME_W-1:0] prev_ts;
    logic              prev_ok;
    logic              prev_valid;
    logic [CFG_W-1:0]  fresh_age_lim;
    logic [CFG_W-1:0]  hold_lim;

    result_t due_results [$];
    row_t    directed_rows [$];

    // bookkeeping
    int mismatch_count = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int stored_count   = 0;
    int outcome_tally [8];
    int stall_cycles   = 0;

    // stimulus controls
    logic [TIME_W-1:0] clock_us     = '0;
    logic              last_cap_ok  = 1'b0;
    int unsigned       gap_odds     = 0;
    logic              no_gaps      = 1'b0;
    logic              rx_quiet     = 1'b0;
    logic              hold_off_req = 1'b0;

    function automatic void wipe_history();
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            ring_ts[k] = '0;
            ring_ok[k] = 1'b0;
            ring_ax[k] = '0;
            ring_ay[k] = '0;
            ring_az[k] = '0;
        end
        wr_slot    = 0;
        used_slots = 0;
        prev_ts    = '0;
        prev_ok    = 1'b0;
        prev_valid = 1'b0;
    endfunction

    // Advances the ring by one word and returns the result word it should give.
    function automatic result_t history_step(input word_t w);
        result_t     r;
        int unsigned k;
        int unsigned slot;
        int unsigned pick;
        logic [63:0] age;
        logic        found;
        logic        have;
        logic        done;
        r = '0;
        r.outcome = OUT_NOT_LOOKUP;
        case (w.cmd)
            CMD_CAPTURE:
            begin
                // zero timestamp and an exact repeat of the last capture are dropped
                if (w.ts != '0 && !(prev_valid && w.ts == prev_ts && w.ok == prev_ok))
                begin
                    ring_ts[wr_slot] = w.ts;
                    ring_ok[wr_slot] = w.ok;
                    ring_ax[wr_slot] = w.ok ? w.ax : '0;
                    ring_ay[wr_slot] = w.ok ? w.ay : '0;
                    ring_az[wr_slot] = w.ok ? w.az : '0;
                    wr_slot = (wr_slot + 1) % HISTORY_DEPTH;
                    if (used_slots < HISTORY_DEPTH)
                        used_slots++;
                    prev_ts    = w.ts;
                    prev_ok    = w.ok;
                    prev_valid = 1'b1;
                    r.stored   = 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                r.outcome = OUT_NONE;
                found = 1'b0;
                have  = 1'b0;
                done  = 1'b0;
                pick  = 0;
                // newest first; entries after the query time are skipped
                for (k = 0; k < used_slots && !done; k++)
                begin
                    slot = (wr_slot + 2 * HISTORY_DEPTH - 1 - k) % HISTORY_DEPTH;
                    if (ring_ts[slot] <= w.ts)
                    begin
                        age = w.ts - ring_ts[slot];
                        if (!found)
                        begin
                            found = 1'b1;
                            if (!ring_ok[slot])
                                r.outcome = OUT_INVALID;
                            else if (age > {32'd0, fresh_age_lim})
                                r.outcome = OUT_STALE;
                            else
                            begin
                                r.outcome = OUT_FRESH;
                                have = 1'b1;
                                pick = slot;
                                done = 1'b1;
                            end
                        end
                        // a stale first entry may still be the held one
                        if (!have && ring_ok[slot] && age <= {32'd0, hold_lim})
                        begin
                            have = 1'b1;
                            pick = slot;
                        end
                    end
                end
                if (have)
                begin
                    r.present = 1'b1;
                    r.ax = ring_ax[pick];
                    r.ay = ring_ay[pick];
                    r.az = ring_az[pick];
                end
            end
            CMD_CLEAR:
                wipe_history();
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_word(input word_t w);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[TIME_W-1:0]                    = w.ts;
        d[TIME_W]                        = w.ok;
        d[TIME_W + 1 +: ACC_W]           = w.ax;
        d[TIME_W + 1 + ACC_W +: ACC_W]   = w.ay;
        d[TIME_W + 1 + 2*ACC_W +: ACC_W] = w.az;
        return d;
    endfunction

    // typed rows always answer with no sample attached
    function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] ts,
                                    input logic ok, input logic [ACC_W-1:0] ax,
                                    input logic [ACC_W-1:0] ay, input logic [ACC_W-1:0] az,
                                    input logic typed, input logic stored,
                                    input logic [2:0] outcome);
        row_t r;
        r = '0;
        r.w.cmd          = cmd;
        r.w.ts           = ts;
        r.w.ok           = ok;
        r.w.ax           = ax;
        r.w.ay           = ay;
        r.w.az           = az;
        r.typed          = typed;
        r.want.stored    = stored;
        r.want.outcome   = outcome;
        directed_rows.push_back(r);
    endfunction

    // Mostly a timeline of captures and lookups around it, with noise mixed in.
    function automatic word_t random_word();
        word_t       w;
        int unsigned sel;
        logic [63:0] step;
        w.ax  = $urandom;
        w.ay  = $urandom;
        w.az  = $urandom;
        w.ok  = ($urandom_range(0, 3) != 0);
        w.cmd = CMD_CAPTURE;
        w.ts  = clock_us;
        sel   = $urandom_range(0, 99);
        if (sel < 40)
        begin
            case ($urandom_range(0, 3))
                0:       step = $urandom_range(1, 64);
                1:       step = $urandom_range(1, 4000);
                2:       step = $urandom_range(1, fresh_age_lim / 3 + 1);
                default: step = $urandom_range(1, hold_lim / 3 + 1);
            endcase
            clock_us = clock_us + step;
            w.ts = clock_us;
            last_cap_ok = w.ok;
        end
        else if (sel < 44)
            w.ok = last_cap_ok;               // same time and validity again
        else if (sel < 46)
            w.ts = '0;
        else if (sel < 49)
            w.ts = {$urandom, $urandom};      // far off the timeline
        else if (sel < 89)
        begin
            w.cmd = CMD_LOOKUP;
            case ($urandom_range(0, 9))
                0:       w.ts = clock_us;
                1:       w.ts = clock_us + {32'd0, fresh_age_lim};
                2:       w.ts = clock_us + {32'd0, fresh_age_lim} + 1;
                3:       w.ts = clock_us + {32'd0, hold_lim};
                4:       w.ts = clock_us + {32'd0, hold_lim} + 1;
                5:       w.ts = clock_us + $urandom_range(0, hold_lim);
                6:       w.ts = clock_us - $urandom_range(1, 3000);
                7:       w.ts = {$urandom, $urandom};
                8:       w.ts = clock_us + {32'd0, $urandom};
                default: w.ts = clock_us + $urandom_range(0, fresh_age_lim);
            endcase
        end
        else if (sel < 92)
        begin
            w.cmd = CMD_CLEAR;
            w.ts  = {$urandom, $urandom};
        end
        else if (sel < 94)
        begin
            w.cmd = CMD_UNUSED;
            w.ts  = {$urandom, $urandom};
        end
        else
            w.ts = clock_us - $urandom_range(1, 1000);  // slightly out of order
        return w;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Offers one word, after a random gap now and then, and returns at its acceptance.
    task automatic send_word(input word_t w, input logic typed, input result_t want);
        int unsigned gap;
        gap = 0;
        if (words_sent % 32 == 0)
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        words_sent++;
        if (!no_gaps && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            gap = $urandom_range(1, 17);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= w.cmd;
        s_tdata   <= pack_word(w);
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (!s_tready);
    endtask

    // Source goes quiet until every result word is home.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Both registers back to back, enable held high across them.
    task automatic apply_setting(input logic [CFG_W-1:0] fresh, input logic [CFG_W-1:0] hold);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_FRESH;
        cfg_data  <= fresh;
        @(posedge clk);
        fresh_age_lim = fresh;
        cfg_index <= REG_HOLD_LIMIT;
        cfg_data  <= hold;
        @(posedge clk);
        hold_lim = hold;
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Sink: bursts of back-pressure in changing moods, one long hold-off
    // ---------------------------------------------------------------
    initial
    begin : sink
        int unsigned odds;
        int unsigned span;
        odds = 0;
        span = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                span = 48;
                odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            end
            span--;
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!rx_quiet && odds != 0 && $urandom_range(1, odds) == 1)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on every accepted input word, checks every result
    // word against the oldest prediction, and runs the watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        word_t   seen;
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.stored  = m_tdata[0];
                got.outcome = m_tdata[3:1];
                got.present = m_tdata[4];
                got.ax      = m_tdata[RES_ACC_LSB +: ACC_W];
                got.ay      = m_tdata[RES_ACC_LSB + ACC_W +: ACC_W];
                got.az      = m_tdata[RES_ACC_LSB + 2*ACC_W +: ACC_W];
                results_seen++;
                if (got.stored)
                    stored_count++;
                if (got.outcome < OUT_NOT_LOOKUP)
                    outcome_tally[got.outcome]++;
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result word with nothing expected, got %0h",
                                 $time, got);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("stored",       want.stored,  got.stored);
                    check_field("outcome",      want.outcome, got.outcome);
                    check_field("data_present", want.present, got.present);
                    check_field("accel_x_out",  want.ax,      got.ax);
                    check_field("accel_y_out",  want.ay,      got.ay);
                    check_field("accel_z_out",  want.az,      got.az);
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen.cmd = s_tuser;
                seen.ts  = s_tdata[TIME_W-1:0];
                seen.ok  = s_tdata[TIME_W];
                seen.ax  = s_tdata[TIME_W + 1 +: ACC_W];
                seen.ay  = s_tdata[TIME_W + 1 + ACC_W +: ACC_W];
                seen.az  = s_tdata[TIME_W + 1 + 2*ACC_W +: ACC_W];
                want = history_step(seen);
                // predictor still steps so the ring stays in line
                if (row_typed)
                    want = row_want;
                due_results.push_back(want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, due_results.size());
                $display("timestamped_sample_history_lookup_unit test failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed table, then random phases under several settings
    // ---------------------------------------------------------------
    initial
    begin : run
        logic [CFG_W-1:0] f;
        logic [CFG_W-1:0] h;
        int               ph;
        int               n;
        int               k;

        foreach (outcome_tally[i])
            outcome_tally[i] = 0;

        // empty ring, zero timestamp, repeated capture, same time new validity
        add_row(CMD_LOOKUP,  64'd0,    1'b0, '0, '0, '0, 1'b1, 1'b0, OUT_NONE);
        add_row(CMD_CAPTURE, 64'd0,    1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                1'b1, 1'b0, OUT_NOT_LOOKUP);
        add_row(CMD_CAPTURE, 64'd1000, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                1'b1, 1'b1, OUT_NOT_LOOKUP);
        add_row(CMD_CAPTURE, 64'd1000, 1'b1, 32'd1, 32'd2, 32'd3, 1'b1, 1'b0, OUT_NOT_LOOKUP);
        add_row(CMD_CAPTURE, 64'd1000, 1'b0, '1, '1, '1, 1'b1, 1'b1, OUT_NOT_LOOKUP);
        // invalid newest entry, older valid one held; then nothing causal
        add_row(CMD_LOOKUP,  64'd1000, 1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        add_row(CMD_LOOKUP,  64'd999,  1'b1, '1, '1, '1, 1'b1, 1'b0, OUT_NONE);
        add_row(CMD_CAPTURE, 64'd2000, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                1'b1, 1'b1, OUT_NOT_LOOKUP);
        // age exactly on and one past each default limit
        add_row(CMD_LOOKUP,  64'd22000,  1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        add_row(CMD_LOOKUP,  64'd22001,  1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        add_row(CMD_LOOKUP,  64'd102000, 1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        add_row(CMD_LOOKUP,  64'd102001, 1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        // unused code, then the top of the time range
        add_row(CMD_UNUSED,  TS_MAX, 1'b1, '1, '1, '1, 1'b1, 1'b0, OUT_NOT_LOOKUP);
        add_row(CMD_CAPTURE, TS_MAX, 1'b1, 32'h0123_4567, 32'h89ab_cdef, 32'h1,
                1'b1, 1'b1, OUT_NOT_LOOKUP);
        add_row(CMD_LOOKUP,  TS_MAX, 1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        add_row(CMD_LOOKUP,  64'd1500, 1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        // wrap the ring so the oldest valid entry is overwritten
        for (k = 0; k < 5; k++)
            add_row(CMD_CAPTURE, 64'(3000 + 1000 * k), (k % 2 == 0), $urandom, $urandom,
                    $urandom, 1'b1, 1'b1, OUT_NOT_LOOKUP);
        add_row(CMD_LOOKUP,  64'd7000, 1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        add_row(CMD_LOOKUP,  64'd1000, 1'b0, '0, '0, '0, 1'b0, 1'b0, OUT_NONE);
        // clear forgets the last capture too
        add_row(CMD_CLEAR,   TS_MAX, 1'b1, '1, '1, '1, 1'b1, 1'b0, OUT_NOT_LOOKUP);
        add_row(CMD_LOOKUP,  TS_MAX, 1'b0, '0, '0, '0, 1'b1, 1'b0, OUT_NONE);
        add_row(CMD_CAPTURE, 64'd7000, 1'b1, 32'd5, 32'd6, 32'd7, 1'b1, 1'b1, OUT_NOT_LOOKUP);

        wipe_history();
        fresh_age_lim = MAX_FRESH_RST;
        hold_lim      = HOLD_LIMIT_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    f = MAX_FRESH_RST;
                    h = HOLD_LIMIT_RST;
                end
                1:
                begin
                    f = '0;
                    h = '0;
                end
                2:
                begin
                    f = '1;
                    h = '1;
                end
                3:
                begin
                    f = '0;
                    h = '1;
                end
                4:
                begin
                    f = '1;
                    h = '0;
                end
                5:
                begin
                    f = 32'd500;
                    h = 32'd3000;
                end
                6:
                begin
                    f = $urandom_range(1, 50000);
                    h = f + $urandom_range(0, 200000);
                end
                7:
                begin
                    f = $urandom;
                    h = $urandom;
                end
                default:
                begin
                    f = $urandom_range(1000, 30000);
                    h = $urandom_range(0, 150000);
                end
            endcase
            apply_setting(f, h);
            // odd phases move the timeline somewhere random in the 64-bit range
            if (ph % 2 == 1)
                clock_us = {$urandom, $urandom};
            no_gaps  = (ph == HOLD_PHASE) || (ph == PHASES - 1);
            rx_quiet = (ph == PHASES - 1);
            if (ph == HOLD_PHASE)
                hold_off_req = 1'b1;
            for (n = 0; n < WORDS_PER_PHASE; n++)
                send_word(random_word(), 1'b0, '0);
            drain();
        end

        repeat (20) @(posedge clk);

        $display("Covered %0d words (%0d result words) under %0d register settings, %0d stored.",
                 words_sent, results_seen, PHASES + 1, stored_count);
        $display("Lookups: fresh %0d, invalid %0d, stale %0d, no entry %0d; %0d mismatches.",
                 outcome_tally[OUT_FRESH], outcome_tally[OUT_INVALID],
                 outcome_tally[OUT_STALE], outcome_tally[OUT_NONE], mismatch_count);
        if (mismatch_count == 0)
            $display("timestamped_sample_history_lookup_unit test passed");
        else
            $display("timestamped_sample_history_lookup_unit test failed");
        $finish;
    end

endmodule
